[rtl/core/hmr_pkg.sv]
// shared types, constants and width helpers for the histogram match pixel remap
package hmr_pkg;

	localparam int PIX_W = 8;
	localparam int REG_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int LATENCY = 13;
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE        = 3'd0,
		CFG_SOURCE_MEAN   = 3'd1,
		CFG_SOURCE_SPREAD = 3'd2,
		CFG_GOAL_MEAN     = 3'd3,
		CFG_GOAL_SPREAD   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic             enable;
		logic [REG_W-1:0] source_mean;
		logic [REG_W-1:0] source_spread;
		logic [REG_W-1:0] goal_mean;
		logic [REG_W-1:0] goal_spread;
	} cfg_t;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic             valid;
		logic             fixed;
		logic [PIX_W-1:0] pix;
	} ctl_t;

	// signed operand width: pixel or register range plus headroom for sums
	function automatic int op_w(input int frac_bits);
		int base;
		base = (frac_bits + PIX_W > REG_W + 1) ? frac_bits + PIX_W : REG_W + 1;
		return base + 3;
	endfunction

	function automatic int num_w(input int frac_bits);
		return 2 * op_w(frac_bits) + 1;
	endfunction

	// divisor is a positive segment width scaled by 2^frac_bits
	function automatic int den_w(input int frac_bits);
		return op_w(frac_bits) - 1 + frac_bits;
	endfunction

	function automatic int rem_w(input int frac_bits);
		return den_w(frac_bits) + PIX_W;
	endfunction

endpackage

[rtl/core/hmr_cfg_regs.sv]
// configuration register file for the remap settings
module hmr_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hmr_pkg::REG_W-1:0]    cfg_data,
	output hmr_pkg::cfg_t                cfg
);
	import hmr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b1;
			cfg_q.source_mean   <= '0;
			cfg_q.source_spread <= '0;
			cfg_q.goal_mean     <= '0;
			cfg_q.goal_spread   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ENABLE:        cfg_q.enable        <= cfg_data[0];
				CFG_SOURCE_MEAN:   cfg_q.source_mean   <= cfg_data;
				CFG_SOURCE_SPREAD: cfg_q.source_spread <= cfg_data;
				CFG_GOAL_MEAN:     cfg_q.goal_mean     <= cfg_data;
				CFG_GOAL_SPREAD:   cfg_q.goal_spread   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/hmr_front.sv]
// segment select, operand build, products and numerator sum (stages 1 to 3)
module hmr_front #(
	parameter int FRAC_BITS = 8
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              accept,
	input  logic [hmr_pkg::PIX_W-1:0]                         pixel_in,
	input  hmr_pkg::cfg_t                                     cfg,
	output hmr_pkg::ctl_t                                     ctl_out,
	output logic signed [hmr_pkg::num_w(FRAC_BITS)-1:0]       num_out,
	output logic [hmr_pkg::den_w(FRAC_BITS)-1:0]              den_out
);
	import hmr_pkg::*;

	localparam int OW = op_w(FRAC_BITS);
	localparam int MW = 2 * OW;
	localparam int NW = num_w(FRAC_BITS);
	localparam int DW = den_w(FRAC_BITS);
	localparam logic signed [OW-1:0] HMAX = OW'(255 * (2 ** FRAC_BITS));
	localparam logic signed [OW-1:0] ONE = OW'(1);

	logic signed [OW-1:0] p, m, d, t, g;
	logic signed [OW-1:0] delta, x2, x3, y2, y3;
	logic signed [OW-1:0] u, v, x, y, w;

	logic signed [OW-1:0] u_s1, v_s1, x_s1, y_s1, w_s1;
	ctl_t                 ctl_s1;
	logic signed [MW-1:0] pa_s2, pb_s2;
	logic [DW-1:0]        den_s2;
	ctl_t                 ctl_s2;
	logic signed [NW-1:0] num_s3;
	logic [DW-1:0]        den_s3;
	ctl_t                 ctl_s3;

	assign p = OW'({pixel_in, {FRAC_BITS{1'b0}}});
	assign m = OW'(cfg.source_mean);
	assign d = OW'(cfg.source_spread);
	assign t = OW'(cfg.goal_mean);
	assign g = OW'(cfg.goal_spread);

	assign delta = t - m;
	assign x2 = m - d;
	assign x3 = m + d;
	assign y2 = (t + g) - (m + d);
	assign y3 = (t - g) - (m - d);

	// numerator is u*v + x*y over divisor w*2^FRAC_BITS
	always_comb begin
		u = p;
		v = ONE;
		x = '0;
		y = '0;
		w = ONE;
		if (cfg.source_spread == '0) begin
			if (p == m) begin
				u = p + delta;
			end else if (p < m) begin
				v = t;
				w = m;
			end else begin
				v = HMAX - m;
				x = delta;
				y = HMAX - p;
				w = HMAX - m;
			end
		end else begin
			if (p == x2) begin
				u = p + y2;
			end else if (p < x2) begin
				v = x2 + y2;
				w = x2;
			end else if (p <= x3) begin
				u = p + y2;
				v = x3 - x2;
				x = p - x2;
				y = y3 - y2;
				w = x3 - x2;
			end else begin
				u = p + y3;
				v = HMAX - x3;
				x = x3 - p;
				y = y3;
				w = HMAX - x3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.fixed <= !cfg.enable;
			ctl_s1.pix   <= pixel_in;
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		u_s1   <= u;
		v_s1   <= v;
		x_s1   <= x;
		y_s1   <= y;
		w_s1   <= w;
		pa_s2  <= MW'(u_s1) * MW'(v_s1);
		pb_s2  <= MW'(x_s1) * MW'(y_s1);
		den_s2 <= {w_s1[OW-2:0], {FRAC_BITS{1'b0}}};
		num_s3 <= NW'(pa_s2) + NW'(pb_s2);
		den_s3 <= den_s2;
	end

	assign ctl_out = ctl_s3;
	assign num_out = num_s3;
	assign den_out = den_s3;

endmodule

[rtl/core/hmr_divider.sv]
// clamp check and pipelined restoring divide, one quotient bit per stage
module hmr_divider #(
	parameter int FRAC_BITS = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  hmr_pkg::ctl_t                               ctl_in,
	input  logic signed [hmr_pkg::num_w(FRAC_BITS)-1:0] num_in,
	input  logic [hmr_pkg::den_w(FRAC_BITS)-1:0]        den_in,
	output logic                                        done,
	output logic [hmr_pkg::PIX_W-1:0]                   pixel_out
);
	import hmr_pkg::*;

	localparam int NW = num_w(FRAC_BITS);
	localparam int DW = den_w(FRAC_BITS);
	localparam int RW = rem_w(FRAC_BITS);
	localparam int QB = PIX_W;

	logic num_pos, sat;

	ctl_t             ctl_s [0:QB];
	logic [RW-1:0]    rem_s [0:QB];
	logic [DW-1:0]    den_s [0:QB];
	logic [PIX_W-1:0] q_s   [0:QB];

	logic             done_q;
	logic [PIX_W-1:0] pixel_q;

	// quotient of 256 or more saturates, so only 0..255 reaches the divide
	assign num_pos = !num_in[NW-1] && (num_in != '0);
	assign sat = num_in[NW-2:0] >= (NW-1)'({den_in, {PIX_W{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0].valid <= ctl_in.valid;
			ctl_s[0].fixed <= ctl_in.fixed || !num_pos || sat;
			ctl_s[0].pix   <= ctl_in.fixed ? ctl_in.pix : (num_pos ? PIX_MAX : '0);
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num_in[RW-1:0];
		den_s[0] <= den_in;
		q_s[0]   <= '0;
	end

	for (genvar k = 0; k < QB; k++) begin : g_bit
		logic [RW-1:0] dsh;
		logic          ge;

		assign dsh = RW'(den_s[k]) << (QB - 1 - k);
		assign ge = rem_s[k] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? rem_s[k] - dsh : rem_s[k];
			den_s[k+1] <= den_s[k];
			q_s[k+1]   <= q_s[k] | (PIX_W'(ge) << (QB - 1 - k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s[QB].valid;
		end
	end

	always_ff @(posedge clk) begin
		pixel_q <= ctl_s[QB].fixed ? ctl_s[QB].pix : q_s[QB];
	end

	assign done = done_q;
	assign pixel_out = pixel_q;

endmodule

[rtl/core/histogram_match_pixel_remap.sv]
// top level of the pixel remap toward a target mean and spread
//
// usage: drive pixel_in with start high for one cycle per item; busy stays low,
// so a new pixel may be given on every clock.
// each item produces one result: done pulses for exactly one cycle with
// pixel_out valid in that cycle. the pipeline has three stages for segment
// select, products and numerator sum, one clamp stage, eight divide stages
// (one quotient bit each) and the output register. throughput is one pixel
// per clock.
// settings are written through cfg_valid/cfg_ready with cfg_index 0..4
// (enable, source mean, source spread, goal mean, goal spread); cfg_ready is
// always high and other indexes are ignored. write only while no item is in
// flight.
// reset clears the pipeline, sets enable and zeroes the other settings.
// the receiver cannot stall, so results are never held back.
module histogram_match_pixel_remap #(
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [hmr_pkg::PIX_W-1:0]     pixel_in,
	output logic                          done,
	output logic [hmr_pkg::PIX_W-1:0]     pixel_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hmr_pkg::REG_W-1:0]     cfg_data
);
	import hmr_pkg::*;

	localparam int NW = num_w(FRAC_BITS);
	localparam int DW = den_w(FRAC_BITS);

	cfg_t                 cfg;
	ctl_t                 ctl_mid;
	logic signed [NW-1:0] num_mid;
	logic [DW-1:0]        den_mid;

	assign busy = 1'b0;

	hmr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hmr_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (start && !busy),
		.pixel_in (pixel_in),
		.cfg      (cfg),
		.ctl_out  (ctl_mid),
		.num_out  (num_mid),
		.den_out  (den_mid)
	);

	hmr_divider #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_mid),
		.num_in    (num_mid),
		.den_in    (den_mid),
		.done      (done),
		.pixel_out (pixel_out)
	);

endmodule

[rtl/core/hmr_checker.sv]
// port-level checks on the pixel remap and their binding to the top level
module hmr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [hmr_pkg::PIX_W-1:0]     pixel_in,
	input logic                          done,
	input logic [hmr_pkg::PIX_W-1:0]     pixel_out,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [hmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hmr_pkg::REG_W-1:0]     cfg_data
);
	import hmr_pkg::*;

	// shadow of the enable setting as seen on the config port
	logic en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready && cfg_index == CFG_ENABLE) begin
			en_q <= cfg_data[0];
		end
	end

	// every accepted item yields its result a fixed latency later
	a_item_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted item gave no result after the pipeline latency");

	// no result without an item accepted a fixed latency earlier
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching accepted item");

	// with the remap off the pixel comes back unchanged
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		done && !$past(en_q, LATENCY) |-> pixel_out == $past(pixel_in, LATENCY))
		else $error("disabled remap altered the pixel");

endmodule

bind histogram_match_pixel_remap hmr_checker u_hmr_checker (.*);
